FILE: src/dges_pkg.sv
// ---------------------------------------------------------------------------
// dges_pkg: shared types and constants for the device graph edge store
// Status codes, request codes and size defaults.
// ---------------------------------------------------------------------------
package dges_pkg;

  localparam int unsigned DevicesDefault = 32;
  localparam int unsigned IdW = 64;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_CONN     = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

endpackage

FILE: src/device_graph_edge_store.sv
// ---------------------------------------------------------------------------
// device_graph_edge_store: device table with directed adjacency matrix
// ---------------------------------------------------------------------------
// One request at a time. The identifier table and the adjacency rows each
// live in a synchronous memory with a registered read, walked one entry at a time.
// An identifier lookup addresses and then compares each table entry in turn;
// an absent identifier is inserted by an add-edge request if room remains.
// A query looks up its identifier, fetches that device's row, scans it for
// outgoing neighbours, scans every row's column for incoming ones and ends
// with a final beat. A consumer that holds off a result beat stalls the walk.
// Results leave through an output register; the next request is taken once
// the final result of the current one has been delivered.
// ---------------------------------------------------------------------------
module device_graph_edge_store
  import dges_pkg::*;
#(
  parameter int unsigned DEVICES = DevicesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  input  logic [63:0]   first_id_i,
  input  logic [63:0]   second_id_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic          direction_o,
  output logic [4:0]    own_index_o,
  output logic [4:0]    peer_index_o,
  output logic [63:0]   peer_id_o,
  output logic          last_o
);

  localparam int unsigned IW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned CW = $clog2(DEVICES + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LADDR = 14'b00000000000010,
    S_LCMP  = 14'b00000000000100,
    S_INS   = 14'b00000000001000,
    S_EDGE  = 14'b00000000010000,
    S_EWR   = 14'b00000000100000,
    S_FULL  = 14'b00000001000000,
    S_ROW   = 14'b00000010000000,
    S_RCAP  = 14'b00000100000000,
    S_RSCAN = 14'b00001000000000,
    S_RID   = 14'b00010000000000,
    S_CADDR = 14'b00100000000000,
    S_CCHK  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  // Memories
  logic [IdW-1:0]     id_mem [DEVICES];
  logic [DEVICES-1:0] adj_mem [DEVICES];
  logic [DEVICES-1:0] adj_vld_q;   // row valid bits, cleared at reset

  state_e           state_q;
  logic [CW-1:0]    total_q;
  logic             req_q;
  logic [IdW-1:0]   a_q, b_q;
  logic             second_q;      // looking up destination
  logic [CW-1:0]    ptr_q;         // walk pointer
  logic [IW-1:0]    src_q, dst_q;
  logic             src_ok_q;
  logic [DEVICES-1:0] row_q;

  // Pending neighbour, held one behind so last can be marked
  logic             pend_q;
  logic             pdir_q;
  logic [IW-1:0]    pidx_q;
  logic [IdW-1:0]   pid_q;

  // Memory read ports
  logic [IW-1:0]      id_raddr, adj_raddr;
  logic [IdW-1:0]     id_rdata_q;
  logic [DEVICES-1:0] adj_rdata_q;
  logic               adj_rvld_q;

  // Output register
  logic          ovld_q;
  logic [2:0]    ost_q;
  logic          odir_q, olast_q;
  logic [4:0]    oown_q, opeer_q;
  logic [63:0]   opid_q;

  logic          out_free;
  assign out_free = !ovld_q || out_ready_i;

  logic [IdW-1:0] key;
  assign key = second_q ? b_q : a_q;

  logic [IW-1:0] ptr_idx;
  assign ptr_idx = ptr_q[IW-1:0];

  assign in_ready_o = (state_q == S_IDLE) && !ovld_q;

  // Read addresses; the source row stays addressed while an edge waits
  always_comb begin
    id_raddr  = ptr_idx;
    adj_raddr = ptr_idx;
    if (state_q == S_EDGE || state_q == S_EWR || state_q == S_ROW) adj_raddr = src_q;
  end

  always_ff @(posedge clk_i) begin
    id_rdata_q <= id_mem[id_raddr];
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_rvld_q <= 1'b0;
    end else begin
      adj_rvld_q <= adj_vld_q[adj_raddr];
    end
  end

  logic [DEVICES-1:0] adj_rd;
  assign adj_rd = adj_rvld_q ? adj_rdata_q : '0;

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (state_q == S_INS && req_q == REQ_ADD && total_q < CW'(DEVICES)) begin
      id_mem[total_q[IW-1:0]] <= key;
    end
    if (state_q == S_EWR && out_free) begin
      adj_mem[src_q] <= adj_rd | (DEVICES'(1) << dst_q);
    end
  end

  // A result beat is loaded this cycle
  logic out_set;
  always_comb begin
    out_set = 1'b0;
    if (out_free) begin
      case (state_q)
        S_INS:                out_set = (req_q == REQ_QUERY);
        S_EWR, S_FULL, S_FIN: out_set = 1'b1;
        S_RID:                out_set = pend_q;
        S_CCHK:               out_set = pend_q && adj_rd[src_q];
        default:              out_set = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= out_set || (ovld_q && !out_ready_i);
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      adj_vld_q <= '0;
      req_q     <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      second_q  <= 1'b0;
      ptr_q     <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      src_ok_q  <= 1'b0;
      row_q     <= '0;
      pend_q    <= 1'b0;
      pdir_q    <= 1'b0;
      pidx_q    <= '0;
      pid_q     <= '0;
      ost_q     <= '0;
      odir_q    <= 1'b0;
      oown_q    <= '0;
      opeer_q   <= '0;
      opid_q    <= '0;
      olast_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q    <= req_type_i;
            a_q      <= first_id_i;
            b_q      <= second_id_i;
            second_q <= 1'b0;
            ptr_q    <= '0;
            src_q    <= '0;
            dst_q    <= '0;
            pend_q   <= 1'b0;
            src_ok_q <= 1'b0;
            state_q  <= S_LADDR;
          end
        end
        S_LADDR: begin
          // read of id_mem[ptr] is in flight
          if (ptr_q >= total_q) state_q <= S_INS;
          else state_q <= S_LCMP;
        end
        S_LCMP: begin
          if (id_rdata_q == key) begin
            if (req_q == REQ_QUERY) begin
              src_q   <= ptr_idx;
              state_q <= S_ROW;
            end else if (!second_q) begin
              src_q <= ptr_idx; src_ok_q <= 1'b1;
              second_q <= 1'b1; ptr_q <= '0; state_q <= S_LADDR;
            end else begin
              dst_q   <= ptr_idx;
              state_q <= src_ok_q ? S_EDGE : S_FULL;
            end
          end else begin
            ptr_q   <= ptr_q + CW'(1);
            state_q <= S_LADDR;
          end
        end
        S_INS: begin
          if (req_q == REQ_QUERY) begin
            if (out_free) begin
              ost_q <= ST_NOTFOUND; odir_q <= 1'b0;
              oown_q <= '0; opeer_q <= '0; opid_q <= '0; olast_q <= 1'b1;
              state_q <= S_IDLE;
            end
          end else if (total_q >= CW'(DEVICES)) begin
            // source failed: the destination is still looked up
            if (!second_q) begin
              second_q <= 1'b1; ptr_q <= '0; state_q <= S_LADDR;
            end else begin
              state_q <= S_FULL;
            end
          end else begin
            total_q <= total_q + CW'(1);
            if (!second_q) begin
              src_q <= total_q[IW-1:0]; src_ok_q <= 1'b1;
              second_q <= 1'b1; ptr_q <= '0; state_q <= S_LADDR;
            end else begin
              dst_q <= total_q[IW-1:0]; state_q <= S_EDGE;
            end
          end
        end
        S_EDGE: state_q <= S_EWR;   // row read in flight
        S_EWR: begin
          if (out_free) begin
            adj_vld_q[src_q] <= 1'b1;
            ost_q <= ST_ADDED; odir_q <= 1'b0;
            oown_q <= 5'(src_q); opeer_q <= 5'(dst_q); opid_q <= '0;
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_FULL: begin
          if (out_free) begin
            ost_q <= ST_FULL; odir_q <= 1'b0;
            oown_q <= 5'(src_q); opeer_q <= 5'(dst_q); opid_q <= '0;
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_ROW: state_q <= S_RCAP;   // source row read in flight
        S_RCAP: begin
          row_q <= adj_rd; ptr_q <= '0; state_q <= S_RSCAN;
        end
        S_RSCAN: begin
          // outgoing: one row bit per cycle, but a set bit waits in S_RID for the output; id read issued alongside
          if (ptr_q >= total_q) begin
            ptr_q <= '0; state_q <= S_CADDR;
          end else if (row_q[ptr_idx]) begin
            state_q <= S_RID;
          end else begin
            ptr_q <= ptr_q + CW'(1);
          end
        end
        S_RID: begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              ost_q <= ST_CONN; odir_q <= pdir_q;
              oown_q <= 5'(src_q); opeer_q <= 5'(pidx_q); opid_q <= pid_q;
              olast_q <= 1'b0;
            end
            pend_q <= 1'b1; pdir_q <= 1'b0; pidx_q <= ptr_idx; pid_q <= id_rdata_q;
            ptr_q <= ptr_q + CW'(1); state_q <= S_RSCAN;
          end
        end
        S_CADDR: begin
          // incoming: row ptr and id ptr are read this cycle
          if (ptr_q >= total_q) state_q <= S_FIN;
          else state_q <= S_CCHK;
        end
        S_CCHK: begin
          if (adj_rd[src_q]) begin
            if (!pend_q || out_free) begin
              if (pend_q) begin
                ost_q <= ST_CONN; odir_q <= pdir_q;
                oown_q <= 5'(src_q); opeer_q <= 5'(pidx_q); opid_q <= pid_q;
                olast_q <= 1'b0;
              end
              pend_q <= 1'b1; pdir_q <= 1'b1; pidx_q <= ptr_idx; pid_q <= id_rdata_q;
              ptr_q <= ptr_q + CW'(1); state_q <= S_CADDR;
            end
          end else begin
            ptr_q <= ptr_q + CW'(1); state_q <= S_CADDR;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (pend_q) begin
              ost_q <= ST_CONN; odir_q <= pdir_q;
              oown_q <= 5'(src_q); opeer_q <= 5'(pidx_q); opid_q <= pid_q;
            end else begin
              ost_q <= ST_NONE; odir_q <= 1'b0;
              oown_q <= 5'(src_q); opeer_q <= '0; opid_q <= '0;
            end
            olast_q <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ovld_q;
  assign status_o     = ost_q;
  assign direction_o  = odir_q;
  assign own_index_o  = oown_q;
  assign peer_index_o = opeer_q;
  assign peer_id_o    = opid_q;
  assign last_o       = olast_q;

  // Assertions
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(DEVICES)) else $error("device count overflow");
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= $past(total_q)) else $error("device count decreased");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_added_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ost_q == ST_ADDED) |-> (CW'(oown_q) < total_q))
    else $error("added index out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !out_ready_i) |=> (ovld_q && $stable(ost_q) && $stable(opid_q)
      && $stable(opeer_q) && $stable(olast_q)))
    else $error("result beat changed while stalled");

endmodule
